[rtl/primitive_to_triangle_list_top_defines.svh]
// assertion macros for the primitive assembly block
`ifndef PRIMITIVE_TO_TRIANGLE_LIST_TOP_DEFINES_SVH
`define PRIMITIVE_TO_TRIANGLE_LIST_TOP_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define P2T_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("primitive assembly assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define P2T_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("primitive assembly assertion failed");

`endif

[rtl/p2t_pkg.sv]
// shared types, codes and constants of the primitive assembly block
`default_nettype none

package p2t_pkg;

   localparam int ID_BITS_DEFAULT = 16;
   localparam int OUT_ID_BITS     = 16;
   localparam int COUNT_BITS      = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam int QUEUE_DEPTH     = 4;

   // input mode codes
   localparam logic [1:0] MODE_BEGIN_POLY = 2'd0;
   localparam logic [1:0] MODE_BEGIN_PRIM = 2'd1;
   localparam logic [1:0] MODE_VERTEX     = 2'd2;
   localparam logic [1:0] MODE_END_PRIM   = 2'd3;

   // primitive kind codes
   localparam logic [2:0] PRIM_LIST  = 3'd0;
   localparam logic [2:0] PRIM_STRIP = 3'd1;
   localparam logic [2:0] PRIM_FAN   = 3'd2;
   localparam logic [2:0] PRIM_LOOP  = 3'd3;

   // result kind codes
   localparam logic [1:0] KIND_TRIANGLE    = 2'd0;
   localparam logic [1:0] KIND_LOOP_VERTEX = 2'd1;
   localparam logic [1:0] KIND_LOOP_END    = 2'd2;

   typedef enum logic [1:0] {
      OP_BEGIN_POLY,
      OP_BEGIN_PRIM,
      OP_VERTEX,
      OP_END_PRIM
   } op_type;

   typedef enum logic [2:0] {
      CLS_LIST,
      CLS_STRIP,
      CLS_FAN,
      CLS_LOOP,
      CLS_UNKNOWN
   } cls_type;

   typedef struct packed {
      op_type  op;
      cls_type cls;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  prim_kind;
      logic [15:0] vtx_id;
   } req_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [OUT_ID_BITS-1:0] id_a;
      logic [OUT_ID_BITS-1:0] id_b;
      logic [OUT_ID_BITS-1:0] id_c;
      logic [COUNT_BITS-1:0]  element_index;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/p2t_front.sv]
// front end: decodes an input beat into a command and a sized vertex id
`default_nettype none

module p2t_front #(
   parameter int ID_BITS = p2t_pkg::ID_BITS_DEFAULT
) (
   input  p2t_pkg::req_type   req_data,
   output p2t_pkg::cmd_type   cmd,
   output logic [ID_BITS-1:0] id
);

   always_comb begin
      unique case (req_data.mode)
         p2t_pkg::MODE_BEGIN_POLY: cmd.op = p2t_pkg::OP_BEGIN_POLY;
         p2t_pkg::MODE_BEGIN_PRIM: cmd.op = p2t_pkg::OP_BEGIN_PRIM;
         p2t_pkg::MODE_VERTEX:     cmd.op = p2t_pkg::OP_VERTEX;
         default:                  cmd.op = p2t_pkg::OP_END_PRIM;
      endcase

      unique case (req_data.prim_kind)
         p2t_pkg::PRIM_LIST:  cmd.cls = p2t_pkg::CLS_LIST;
         p2t_pkg::PRIM_STRIP: cmd.cls = p2t_pkg::CLS_STRIP;
         p2t_pkg::PRIM_FAN:   cmd.cls = p2t_pkg::CLS_FAN;
         p2t_pkg::PRIM_LOOP:  cmd.cls = p2t_pkg::CLS_LOOP;
         default:             cmd.cls = p2t_pkg::CLS_UNKNOWN;
      endcase
   end

   assign id = ID_BITS'(req_data.vtx_id);

endmodule

`default_nettype wire

[rtl/p2t_queue.sv]
// small register queue between the front and back ends
`default_nettype none

module p2t_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH    = p2t_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

[rtl/p2t_back.sv]
// back end: primitive state, triangle assembly and the result register
`default_nettype none

module p2t_back #(
   parameter int ID_BITS = p2t_pkg::ID_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  p2t_pkg::cmd_type   cmd,
   input  logic [ID_BITS-1:0] id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output p2t_pkg::rsp_type   rsp_data
);

   localparam int WIDE_BITS = ID_BITS + p2t_pkg::OUT_ID_BITS;

   p2t_pkg::cls_type                 cls_ff, cls_in;
   logic [ID_BITS-1:0]               first_ff, first_in;
   logic [ID_BITS-1:0]               older_ff, older_in;
   logic [ID_BITS-1:0]               newer_ff, newer_in;
   logic [1:0]                       seen_ff, seen_in;
   logic [1:0]                       phase_ff, phase_in;
   logic                             parity_ff, parity_in;
   logic [p2t_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   p2t_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                             pop;
   logic                             tri_try, tri_ok;
   logic                             loop_vtx, loop_end, take;
   logic [ID_BITS-1:0]               tri_a, tri_b, tri_c;

   function automatic logic [p2t_pkg::OUT_ID_BITS-1:0] out_id(input logic [ID_BITS-1:0] v);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(v);
      return wide[p2t_pkg::OUT_ID_BITS-1:0];
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = cmd_valid && cmd_ready;

   // per-command state update
   always_comb begin
      cls_in    = cls_ff;
      first_in  = first_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;
      seen_in   = seen_ff;
      phase_in  = phase_ff;
      parity_in = parity_ff;
      tri_try   = 1'b0;
      tri_a     = older_ff;
      tri_b     = newer_ff;
      tri_c     = id;
      loop_vtx  = 1'b0;
      loop_end  = 1'b0;

      unique case (cmd.op)
         p2t_pkg::OP_BEGIN_POLY: begin
         end
         p2t_pkg::OP_BEGIN_PRIM: begin
            cls_in    = cmd.cls;
            seen_in   = '0;
            phase_in  = '0;
            parity_in = 1'b0;
         end
         p2t_pkg::OP_END_PRIM: begin
            loop_end = (cls_ff == p2t_pkg::CLS_LOOP);
         end
         default: begin
            unique case (cls_ff)
               p2t_pkg::CLS_LIST: begin
                  if (phase_ff == 2'd0) begin
                     older_in = id;
                     phase_in = 2'd1;
                  end else if (phase_ff == 2'd1) begin
                     newer_in = id;
                     phase_in = 2'd2;
                  end else begin
                     tri_try  = 1'b1;
                     phase_in = 2'd0;
                  end
               end
               p2t_pkg::CLS_STRIP: begin
                  if (seen_ff >= 2'd2) begin
                     tri_try   = 1'b1;
                     tri_a     = parity_ff ? newer_ff : older_ff;
                     tri_b     = parity_ff ? older_ff : newer_ff;
                     parity_in = !parity_ff;
                  end else begin
                     seen_in = seen_ff + 1'b1;
                  end
                  older_in = newer_ff;
                  newer_in = id;
               end
               p2t_pkg::CLS_FAN: begin
                  if (seen_ff == 2'd0) begin
                     first_in = id;
                     seen_in  = 2'd1;
                  end else if (seen_ff == 2'd1) begin
                     seen_in = 2'd2;
                  end else begin
                     tri_try = 1'b1;
                     tri_a   = first_ff;
                  end
                  older_in = newer_ff;
                  newer_in = id;
               end
               p2t_pkg::CLS_LOOP: begin
                  loop_vtx = 1'b1;
               end
               default: begin
               end
            endcase
         end
      endcase
   end

   // result formation and element counting
   always_comb begin
      tri_ok = tri_try && (tri_a != tri_b) && (tri_b != tri_c) && (tri_a != tri_c);
      take   = tri_ok || loop_end;

      if (cmd.op == p2t_pkg::OP_BEGIN_POLY) begin
         count_in = '0;
      end else if (take && (count_ff != p2t_pkg::COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end

      rsp_in               = '0;
      rsp_in.element_index = count_ff;
      if (tri_ok) begin
         rsp_in.kind = p2t_pkg::KIND_TRIANGLE;
         rsp_in.id_a = out_id(tri_a);
         rsp_in.id_b = out_id(tri_b);
         rsp_in.id_c = out_id(tri_c);
      end else if (loop_vtx) begin
         rsp_in.kind = p2t_pkg::KIND_LOOP_VERTEX;
         rsp_in.id_a = out_id(id);
      end else begin
         rsp_in.kind = p2t_pkg::KIND_LOOP_END;
      end

      if (pop) begin
         rsp_valid_in = tri_ok || loop_vtx || loop_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff       <= p2t_pkg::CLS_LIST;
         first_ff     <= '0;
         older_ff     <= '0;
         newer_ff     <= '0;
         seen_ff      <= '0;
         phase_ff     <= '0;
         parity_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            cls_ff    <= cls_in;
            first_ff  <= first_in;
            older_ff  <= older_in;
            newer_ff  <= newer_in;
            seen_ff   <= seen_in;
            phase_ff  <= phase_in;
            parity_ff <= parity_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/primitive_to_triangle_list_top.sv]
// top level of the primitive assembly block: front decode, queue, back end
`default_nettype none

// Turns a stream of polygon/primitive/vertex events into triangles and
// line-loop elements. One beat is taken per cycle while the queue is not
// full, and each beat makes at most one result; the back end updates its
// primitive state on each command it takes, so the sustained rate is one
// beat per clock while the result side does not stall. A result passes
// through the four-entry command queue and then the result register; while
// the result side stalls, the queue keeps taking beats until it holds four.

module primitive_to_triangle_list_top #(
   parameter int ID_BITS = p2t_pkg::ID_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  p2t_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output p2t_pkg::rsp_type rsp_data
);

   localparam int CMD_BITS = $bits(p2t_pkg::cmd_type);
   localparam int Q_WIDTH  = CMD_BITS + ID_BITS;

   p2t_pkg::cmd_type   front_cmd, back_cmd;
   logic [ID_BITS-1:0] front_id, back_id;
   logic [Q_WIDTH-1:0] q_in_data, q_out_data;
   logic               q_out_valid, q_out_ready;

   p2t_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .req_data (req_data),
      .cmd      (front_cmd),
      .id       (front_id)
   );

   assign q_in_data = {front_cmd, front_id};

   p2t_queue #(
      .WIDTH (Q_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   assign back_cmd = p2t_pkg::cmd_type'(q_out_data[Q_WIDTH-1:ID_BITS]);
   assign back_id  = q_out_data[ID_BITS-1:0];

   p2t_back #(
      .ID_BITS (ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_out_valid),
      .cmd_ready (q_out_ready),
      .cmd       (back_cmd),
      .id        (back_id),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/p2t_checker.sv]
// port-level checks of the primitive assembly block and their binding
`default_nettype none

`include "primitive_to_triangle_list_top_defines.svh"

module p2t_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire p2t_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire p2t_pkg::rsp_type rsp_data
);

   // stalled result beat holds
   `P2T_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // emitted triangles are never degenerate
   `P2T_ASSERT_IMP(a_tri_distinct, rsp_valid && rsp_data.kind == p2t_pkg::KIND_TRIANGLE, rsp_data.id_a != rsp_data.id_b && rsp_data.id_b != rsp_data.id_c && rsp_data.id_a != rsp_data.id_c)

   // loop vertices carry only the first id; loop ends carry no id
   `P2T_ASSERT_IMP(a_loop_zero, rsp_valid && rsp_data.kind != p2t_pkg::KIND_TRIANGLE, rsp_data.id_b == '0 && rsp_data.id_c == '0 && (rsp_data.kind == p2t_pkg::KIND_LOOP_VERTEX || rsp_data.id_a == '0))

   // nothing pending right after reset
   `P2T_ASSERT_IMP(a_reset_idle, $past(reset), !rsp_valid && req_ready)

endmodule

bind primitive_to_triangle_list_top p2t_checker u_p2t_checker (.*);

`default_nettype wire

[test/primitive_to_triangle_list_top_test.sv]
// self-checking testbench of the primitive assembly block: directed beats, then random primitives
`default_nettype none

module primitive_to_triangle_list_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import p2t_pkg::*;

   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_SILENT,
      CHK_GIVEN
   } chk_type;

   typedef struct packed {
      req_type beat;
      chk_type chk;
      rsp_type given;
   } stim_row;

   localparam logic [2:0] PRIM_ODD_KIND = 3'd7;
   localparam rsp_type    NO_RSP        = '0;
   localparam int         NUM_DIRECTED  = 26;
   localparam int         NUM_RANDOM    = 650;
   localparam int         QUIET_TAIL    = 120;

   localparam stim_row DIRECTED_BEATS [NUM_DIRECTED] = '{
      '{'{MODE_BEGIN_POLY, PRIM_ODD_KIND, 16'hffff}, CHK_SILENT, NO_RSP},
      '{'{MODE_BEGIN_PRIM, PRIM_LIST, 16'h0000}, CHK_SILENT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_LIST, 16'h0000}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_LIST, 16'hffff}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_LIST, 16'h0001}, CHK_GIVEN,
        '{KIND_TRIANGLE, 16'h0000, 16'hffff, 16'h0001, 24'd0}},
      '{'{MODE_VERTEX, PRIM_LIST, 16'h0005}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_LIST, 16'h0005}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_LIST, 16'h0009}, CHK_SILENT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_LIST, 16'h0002}, CHK_PREDICT, NO_RSP},
      '{'{MODE_END_PRIM, PRIM_LIST, 16'h0000}, CHK_SILENT, NO_RSP},
      '{'{MODE_BEGIN_PRIM, PRIM_STRIP, 16'h0000}, CHK_SILENT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_STRIP, 16'd10}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_STRIP, 16'd20}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_STRIP, 16'd30}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_STRIP, 16'd40}, CHK_PREDICT, NO_RSP},
      '{'{MODE_BEGIN_PRIM, PRIM_FAN, 16'h0000}, CHK_SILENT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_FAN, 16'd100}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_FAN, 16'd200}, CHK_PREDICT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_FAN, 16'd300}, CHK_PREDICT, NO_RSP},
      '{'{MODE_BEGIN_PRIM, PRIM_LOOP, 16'h0000}, CHK_SILENT, NO_RSP},
      '{'{MODE_END_PRIM, PRIM_LOOP, 16'h0000}, CHK_GIVEN,
        '{KIND_LOOP_END, 16'h0000, 16'h0000, 16'h0000, 24'd4}},
      '{'{MODE_VERTEX, PRIM_LOOP, 16'habcd}, CHK_PREDICT, NO_RSP},
      '{'{MODE_END_PRIM, PRIM_LOOP, 16'h0000}, CHK_PREDICT, NO_RSP},
      '{'{MODE_BEGIN_PRIM, PRIM_ODD_KIND, 16'hffff}, CHK_SILENT, NO_RSP},
      '{'{MODE_VERTEX, PRIM_ODD_KIND, 16'h1234}, CHK_SILENT, NO_RSP},
      '{'{MODE_END_PRIM, PRIM_ODD_KIND, 16'h0000}, CHK_SILENT, NO_RSP}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // assembly state
   logic [2:0]            open_kind;
   logic [15:0]           fan_first;
   logic [15:0]           id_older;
   logic [15:0]           id_newer;
   logic [1:0]            ids_seen;
   logic [1:0]            list_pos;
   logic                  strip_odd;
   logic [COUNT_BITS-1:0] elem_count;

   stim_row stim_q [$];
   rsp_type pending_elems [$];
   int      gap_pct;
   int      faults;
   int      beats_taken;
   int      tri_seen;
   int      loop_vtx_seen;
   int      loop_end_seen;

   primitive_to_triangle_list_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [COUNT_BITS-1:0] take_index();
      logic [COUNT_BITS-1:0] idx;
      idx = elem_count;
      if (elem_count != COUNT_MAX) elem_count = elem_count + 1'b1;
      return idx;
   endfunction

   function automatic bit make_triangle(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] c, output rsp_type r);
      r = '0;
      if (a == b || b == c || a == c) return 1'b0;
      r.kind = KIND_TRIANGLE;
      r.id_a = a;
      r.id_b = b;
      r.id_c = c;
      r.element_index = take_index();
      return 1'b1;
   endfunction

   function automatic bit assemble_beat(input req_type b, output rsp_type r);
      bit          hit;
      logic [15:0] v;
      hit = 1'b0;
      r = '0;
      v = b.vtx_id;
      case (b.mode)
         MODE_BEGIN_POLY: begin
            elem_count = '0;
         end
         MODE_BEGIN_PRIM: begin
            open_kind = b.prim_kind;
            ids_seen = '0;
            list_pos = '0;
            strip_odd = 1'b0;
         end
         MODE_END_PRIM: begin
            if (open_kind == PRIM_LOOP) begin
               r.kind = KIND_LOOP_END;
               r.element_index = take_index();
               hit = 1'b1;
            end
         end
         default: begin
            case (open_kind)
               PRIM_LIST: begin
                  if (list_pos == 2'd0) begin
                     id_older = v;
                     list_pos = 2'd1;
                  end else if (list_pos == 2'd1) begin
                     id_newer = v;
                     list_pos = 2'd2;
                  end else begin
                     hit = make_triangle(id_older, id_newer, v, r);
                     list_pos = 2'd0;
                  end
               end
               PRIM_STRIP: begin
                  if (ids_seen == 2'd2) begin
                     if (strip_odd) hit = make_triangle(id_newer, id_older, v, r);
                     else hit = make_triangle(id_older, id_newer, v, r);
                     strip_odd = ~strip_odd;
                  end else begin
                     ids_seen = ids_seen + 1'b1;
                  end
                  id_older = id_newer;
                  id_newer = v;
               end
               PRIM_FAN: begin
                  if (ids_seen == 2'd0) begin
                     fan_first = v;
                     ids_seen = 2'd1;
                  end else if (ids_seen == 2'd1) begin
                     ids_seen = 2'd2;
                  end else begin
                     hit = make_triangle(fan_first, id_newer, v, r);
                  end
                  id_older = id_newer;
                  id_newer = v;
               end
               PRIM_LOOP: begin
                  r.kind = KIND_LOOP_VERTEX;
                  r.id_a = v;
                  r.element_index = elem_count;
                  hit = 1'b1;
               end
               default: begin
               end
            endcase
         end
      endcase
      return hit;
   endfunction

   task automatic add_beat(input logic [1:0] m, input logic [2:0] k, input logic [15:0] id);
      stim_row row;
      row.beat.mode = m;
      row.beat.prim_kind = k;
      row.beat.vtx_id = id;
      row.chk = CHK_PREDICT;
      row.given = NO_RSP;
      stim_q = {stim_q, row};
   endtask

   function automatic logic [15:0] pick_id(input bit narrow);
      if (narrow) return 16'($urandom_range(0, 5));
      return 16'($urandom);
   endfunction

   task automatic build_random();
      int          made;
      int          nv;
      bit          narrow;
      logic [2:0]  k;
      made = 0;
      while (made < NUM_RANDOM) begin
         if ($urandom_range(0, 9) == 0) begin
            add_beat(2'($urandom), 3'($urandom), 16'($urandom));
            made++;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               add_beat(MODE_BEGIN_POLY, 3'($urandom), 16'($urandom));
               made++;
            end
            if ($urandom_range(0, 9) < 9) k = 3'($urandom_range(0, 3));
            else k = 3'($urandom_range(4, 7));
            add_beat(MODE_BEGIN_PRIM, k, 16'($urandom));
            nv = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 9);
            narrow = ($urandom_range(0, 2) == 0);
            repeat (nv) add_beat(MODE_VERTEX, 3'($urandom), pick_id(narrow));
            if ($urandom_range(0, 7) != 0) add_beat(MODE_END_PRIM, 3'($urandom), 16'($urandom));
            made += nv + 2;
         end
      end
   endtask

   initial begin
      stim_row row;
      rsp_type pred;
      bit      hit;
      int      gap;
      int      total;
      int      drain_at;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      gap_pct = 0;
      faults = 0;
      beats_taken = 0;
      tri_seen = 0;
      loop_vtx_seen = 0;
      loop_end_seen = 0;
      open_kind = PRIM_LIST;
      fan_first = '0;
      id_older = '0;
      id_newer = '0;
      ids_seen = '0;
      list_pos = '0;
      strip_odd = 1'b0;
      elem_count = '0;
      for (int i = 0; i < NUM_DIRECTED; i++) stim_q = {stim_q, DIRECTED_BEATS[i]};
      build_random();
      total = stim_q.size();
      drain_at = NUM_DIRECTED + (total - NUM_DIRECTED) / 2;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < total; i++) begin
         row = stim_q[i];
         if (i % 80 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 8;
               default: gap_pct = 25;
            endcase
         end
         if (i >= total - QUIET_TAIL) gap_pct = 0;
         if ((i == NUM_DIRECTED || i == drain_at) && pending_elems.size() != 0) begin
            req_valid <= 1'b0;
            while (pending_elems.size() != 0) @(posedge clock);
         end
         if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 13);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= row.beat;
         do @(posedge clock); while (!req_ready);
         beats_taken++;
         hit = assemble_beat(row.beat, pred);
         if (row.chk == CHK_GIVEN) pending_elems = {pending_elems, row.given};
         else if (row.chk == CHK_PREDICT && hit) pending_elems = {pending_elems, pred};
      end
      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d beats through list, strip, fan, loop and unknown primitives, with stalls",
               beats_taken);
      $display("checked %0d triangles, %0d loop vertices, %0d loop ends; %0d mismatches",
               tri_seen, loop_vtx_seen, loop_end_seen, faults);
      if (faults == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            rsp_ready <= 1'b0;
            stall = $urandom_range(1, 13) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_elems.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected beat: kind %0d ids %h %h %h index %0d", rsp_data.kind,
                        rsp_data.id_a, rsp_data.id_b, rsp_data.id_c, rsp_data.element_index);
         end else begin
            want = pending_elems.pop_front();
            case (want.kind)
               KIND_TRIANGLE: tri_seen++;
               KIND_LOOP_VERTEX: loop_vtx_seen++;
               default: loop_end_seen++;
            endcase
            if (rsp_data.kind !== want.kind || rsp_data.id_a !== want.id_a ||
                rsp_data.id_b !== want.id_b || rsp_data.id_c !== want.id_c ||
                rsp_data.element_index !== want.element_index) begin
               faults++;
               if (faults <= 10)
                  $display({"mismatch: exp kind %0d ids %h %h %h index %0d,",
                            " got kind %0d ids %h %h %h index %0d"},
                           want.kind, want.id_a, want.id_b, want.id_c, want.element_index,
                           rsp_data.kind, rsp_data.id_a, rsp_data.id_b, rsp_data.id_c,
                           rsp_data.element_index);
            end
         end
      end
   end

endmodule

`default_nettype wire
